/* hw/rtl/tlhi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhi_pkg: shared types and constants for the three level hash insert
// Payload structs, register indexes, controller states and command bundles.
// ----------------------------------------------------------------------------
package tlhi_pkg;

   localparam int LEVEL_DEPTH = 65536;
   localparam int SLOT_W      = $clog2(LEVEL_DEPTH);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int KEY_W       = 64;
   localparam int MOD_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int DIV_CNT_W   = $clog2(KEY_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_LEVEL1 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL3 = 2'd2;

   localparam logic [1:0] STATUS_FIRST  = 2'd0;
   localparam logic [1:0] STATUS_ADJUST = 2'd1;
   localparam logic [1:0] STATUS_DROP   = 2'd2;

   typedef struct packed {
      logic [63:0] insert_key;
      logic [31:0] item_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  insert_status;
      logic        reverse_order;
      logic [63:0] dropped_key;
   } rsp_type;

   // Level selector: one-hot-free code 0..2 for levels 1..3
   typedef enum logic [1:0] {
      LVL_1 = 2'd0,
      LVL_2 = 2'd1,
      LVL_3 = 2'd2
   } level_type;

   // Which value feeds the divider and the write path
   typedef enum logic [1:0] {
      SRC_KEY   = 2'd0,
      SRC_MOVED = 2'd1,
      SRC_OLD   = 2'd2
   } src_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic      clear_step;
      logic      load_req;
      logic      div_start;
      logic      rd_en;
      logic      wr_en;
      logic      capture_moved;
      logic      capture_old;
      logic      set_result;
      logic [1:0] status;
      logic      drop_old;
      level_type level;
      src_type   src;
   } ctrl_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic key_zero;
      logic reverse;
      logic slot_free;
   } stat_type;

endpackage

/* hw/rtl/tlhi_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhi_divider: restoring remainder unit
// One quotient bit per cycle; gives key mod divisor when done.
// ----------------------------------------------------------------------------
module tlhi_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tlhi_pkg::KEY_W-1:0]  dividend,
   input  logic [tlhi_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic [tlhi_pkg::SLOT_W-1:0] remainder
);
   import tlhi_pkg::*;

   logic [KEY_W-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[KEY_W-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         cnt_in   = DIV_CNT_W'(KEY_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) rem_in = CNT_W'(trial - {1'b0, dvs_ff});
         else                         rem_in = trial[CNT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

/* hw/rtl/tlhi_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhi_datapath: tables, key registers, modulus registers and divider
// Three single-port level memories with registered read data.
// ----------------------------------------------------------------------------
module tlhi_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  tlhi_pkg::ctrl_type           ctrl,
   output tlhi_pkg::stat_type           stat,
   input  tlhi_pkg::req_type            req_data,
   input  logic                         cfg_we,
   input  logic [1:0]                   cfg_index,
   input  logic [tlhi_pkg::MOD_W-1:0]   cfg_data,
   output tlhi_pkg::rsp_type            rsp_data
);
   import tlhi_pkg::*;

   logic [KEY_W-1:0] l1_mem [LEVEL_DEPTH];
   logic [KEY_W-1:0] l2_mem [LEVEL_DEPTH];
   logic [KEY_W-1:0] l3_mem [LEVEL_DEPTH];

   logic [MOD_W-1:0]  mod1_ff, mod2_ff, mod3_ff;
   logic [KEY_W-1:0]  key_ff, moved_ff, old_ff;
   logic              rev_ff;
   logic [KEY_W-1:0]  rd1_ff, rd2_ff, rd3_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W:0]   clr_ff, clr_in;
   rsp_type           rsp_ff;

   logic [KEY_W-1:0]  src_val, rd_val;
   logic [MOD_W-1:0]  mod_sel;
   logic [CNT_W-1:0]  eff_mod;
   logic              div_done;
   logic [SLOT_W-1:0] rem;

   always_comb begin
      unique case (ctrl.src)
         SRC_MOVED: src_val = moved_ff;
         SRC_OLD:   src_val = old_ff;
         default:   src_val = key_ff;
      endcase
      unique case (ctrl.level)
         LVL_2:   begin mod_sel = mod2_ff; rd_val = rd2_ff; end
         LVL_3:   begin mod_sel = mod3_ff; rd_val = rd3_ff; end
         default: begin mod_sel = mod1_ff; rd_val = rd1_ff; end
      endcase
      if (mod_sel == '0)                               eff_mod = CNT_W'(1);
      else if (mod_sel > MOD_W'(LEVEL_DEPTH))          eff_mod = CNT_W'(LEVEL_DEPTH);
      else                                             eff_mod = CNT_W'(mod_sel);
   end

   tlhi_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (src_val),
      .divisor   (eff_mod),
      .done      (div_done),
      .remainder (rem)
   );

   assign clr_in = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod1_ff <= MOD_W'(LEVEL_DEPTH);
         mod2_ff <= MOD_W'(LEVEL_DEPTH);
         mod3_ff <= MOD_W'(LEVEL_DEPTH);
         clr_ff  <= '0;
      end else begin
         if (cfg_we) begin
            priority case (cfg_index)
               REG_LEVEL1: mod1_ff <= cfg_data;
               REG_LEVEL2: mod2_ff <= cfg_data;
               REG_LEVEL3: mod3_ff <= cfg_data;
               default: ;
            endcase
         end
         if (ctrl.clear_step) clr_ff <= clr_in;
      end
   end

   // memories: clearing sweep or a single keyed write, registered reads
   always_ff @(posedge clock) begin
      if (ctrl.clear_step) begin
         l1_mem[clr_ff[SLOT_W-1:0]] <= '0;
         l2_mem[clr_ff[SLOT_W-1:0]] <= '0;
         l3_mem[clr_ff[SLOT_W-1:0]] <= '0;
      end else if (ctrl.wr_en) begin
         unique case (ctrl.level)
            LVL_2:   l2_mem[slot_ff] <= src_val;
            LVL_3:   l3_mem[slot_ff] <= src_val;
            default: l1_mem[slot_ff] <= src_val;
         endcase
      end
      if (ctrl.rd_en) begin
         rd1_ff <= l1_mem[slot_ff];
         rd2_ff <= l2_mem[slot_ff];
         rd3_ff <= l3_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         key_ff <= req_data.insert_key;
         rev_ff <= req_data.item_index[2];
      end
      if (div_done) slot_ff <= rem;
      if (ctrl.capture_moved) moved_ff <= rd_val;
      if (ctrl.capture_old)   old_ff   <= rd_val;
      if (ctrl.set_result) begin
         rsp_ff.insert_status <= ctrl.status;
         rsp_ff.reverse_order <= rev_ff;
         rsp_ff.dropped_key   <= ctrl.drop_old ? old_ff : '0;
      end
   end

   assign stat.clear_done = (clr_ff == (SLOT_W+1)'(LEVEL_DEPTH));
   assign stat.div_done   = div_done;
   assign stat.key_zero   = (key_ff == '0);
   assign stat.reverse    = rev_ff;
   assign stat.slot_free  = (rd_val == '0) || (rd_val == src_val);
   assign rsp_data        = rsp_ff;

endmodule

/* hw/rtl/tlhi_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhi_control: insert sequencer
// Walks probes, displacement and adjustment one table access at a time.
// ----------------------------------------------------------------------------
module tlhi_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tlhi_pkg::stat_type stat,
   output tlhi_pkg::ctrl_type ctrl
);
   import tlhi_pkg::*;

   // probe steps: 0..2 first pass, 3 displace level 3 (forward), 4 adjust l1,
   // 5 adjust l2, 6 adjust l3
   localparam logic [2:0] STEP_P0 = 3'd0;
   localparam logic [2:0] STEP_P1 = 3'd1;
   localparam logic [2:0] STEP_P2 = 3'd2;
   localparam logic [2:0] STEP_DSP = 3'd3;
   localparam logic [2:0] STEP_A1 = 3'd4;
   localparam logic [2:0] STEP_A2 = 3'd5;
   localparam logic [2:0] STEP_A3 = 3'd6;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       adj_ff, adj_in;   // adjustment key is the displaced occupant

   level_type  lvl;
   src_type    src;

   always_comb begin
      unique case (step_ff)
         STEP_P0: lvl = stat.reverse ? LVL_3 : LVL_1;
         STEP_P1: lvl = LVL_2;
         STEP_P2: lvl = stat.reverse ? LVL_1 : LVL_3;
         STEP_DSP: lvl = LVL_3;
         STEP_A1: lvl = LVL_1;
         STEP_A2: lvl = LVL_2;
         default: lvl = LVL_3;
      endcase
      if (step_ff == STEP_A1)      src = adj_ff ? SRC_MOVED : SRC_KEY;
      else if (step_ff >= STEP_A2) src = SRC_OLD;
      else                         src = SRC_KEY;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      adj_in       = adj_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl         = '0;
      ctrl.level   = lvl;
      ctrl.src     = src;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = !stat.clear_done;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               ctrl.load_req = 1'b1;
               step_in  = STEP_P0;
               adj_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.key_zero) begin
               ctrl.set_result = 1'b1;
               ctrl.status     = STATUS_FIRST;
               state_in        = ST_RESULT;
            end else begin
               ctrl.div_start = 1'b1;
               state_in       = ST_READ;
            end
         end
         // slot register loads with the remainder on divider done
         ST_READ: begin
            if (stat.div_done) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            ctrl.rd_en = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            unique case (step_ff)
               STEP_P0, STEP_P1, STEP_P2: begin
                  if (stat.slot_free) begin
                     ctrl.wr_en      = 1'b1;
                     ctrl.set_result = 1'b1;
                     ctrl.status     = STATUS_FIRST;
                     state_in        = ST_RESULT;
                  end else if (step_ff == STEP_P2) begin
                     step_in  = stat.reverse ? STEP_A1 : STEP_DSP;
                     // forward: level 3 slot already addressed, re-read it
                     state_in = stat.reverse ? ST_DIV : ST_WAIT;
                  end else begin
                     step_in  = step_ff + 3'd1;
                     state_in = ST_DIV;
                  end
               end
               STEP_DSP: begin
                  ctrl.capture_moved = 1'b1;
                  ctrl.wr_en         = 1'b1;
                  adj_in             = 1'b1;
                  step_in            = STEP_A1;
                  state_in           = ST_DIV;
               end
               STEP_A1: begin
                  // key replaces the level 1 occupant; a free or equal
                  // occupant ends the pass
                  ctrl.capture_old = 1'b1;
                  ctrl.wr_en       = 1'b1;
                  if (stat.slot_free) begin
                     ctrl.set_result = 1'b1;
                     ctrl.status     = STATUS_ADJUST;
                     state_in        = ST_RESULT;
                  end else begin
                     step_in  = STEP_A2;
                     state_in = ST_DIV;
                  end
               end
               STEP_A2, STEP_A3: begin
                  if (stat.slot_free) begin
                     ctrl.wr_en      = 1'b1;
                     ctrl.set_result = 1'b1;
                     ctrl.status     = STATUS_ADJUST;
                     state_in        = ST_RESULT;
                  end else if (step_ff == STEP_A3) begin
                     ctrl.set_result = 1'b1;
                     ctrl.status     = STATUS_DROP;
                     ctrl.drop_old   = 1'b1;
                     state_in        = ST_RESULT;
                  end else begin
                     step_in  = STEP_A3;
                     state_in = ST_DIV;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RESULT: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_P0;
         adj_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         adj_ff       <= adj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !((state_ff == ST_IDLE) && !rsp_valid_ff);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/three_level_hash_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_hash_insert: three level hash table insert with displacement
// Sequencer plus datapath holding three key tables and a remainder unit.
//
//   channel | handshake          | payload
//   req     | req_valid/req_stall| tlhi_pkg::req_type
//   rsp     | rsp_valid/rsp_stall| tlhi_pkg::rsp_type
//   csr     | csr_valid/csr_ready| csr_index, csr_data
//
// Each table access runs start, the remainder steps, done, read and check.
// The result is offered without a table access for a zero key, else after
// up to six accesses plus a level 3 displacement; every access but the
// displacement runs through the shared divider.
// After reset a clearing sweep over all LEVEL_DEPTH slots runs before the first
// transfer is taken. One item is in work at a time; a waiting result blocks
// the next item, which is taken the cycle after the result transfer.
// ----------------------------------------------------------------------------
module three_level_hash_insert (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tlhi_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tlhi_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [tlhi_pkg::MOD_W-1:0] csr_data
);
   import tlhi_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   tlhi_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tlhi_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .stat      (stat),
      .req_data  (req_data),
      .cfg_we    (csr_valid),
      .cfg_index (csr_index),
      .cfg_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   assign csr_ready = 1'b1;

endmodule
